>>> src/swmf_pkg.sv
// ============================================================================
// Sliding window median filter package
// Shared sizes and the types that link the control logic to the cells.
// ============================================================================
package swmf_pkg;

    localparam int MAX_WINDOW  = 31;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_BITS    = 5;
    localparam int WS_RESET    = 5;

    localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_BITS  = $clog2(MAX_WINDOW);
    localparam int HALF_BITS = $clog2(MAX_WINDOW / 2 + 1);

    typedef struct packed {
        logic                   push;
        logic                   start;
        logic [SAMPLE_BITS-1:0] sample;
        logic [IDX_BITS-1:0]    next_age;
        logic [WIN_BITS-1:0]    win;
    } swmf_ctl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [IDX_BITS-1:0]    age;
        logic                   gt;
    } swmf_entry_t;

endpackage

>>> src/swmf_cell.sv
// ============================================================================
// Sorted window cell
// Holds one entry of the sorted window and moves it to or from a neighbor.
// ============================================================================
module swmf_cell (
    input  logic                           clk,
    input  swmf_pkg::swmf_ctl_t            ctl,
    input  logic [swmf_pkg::IDX_BITS-1:0]  idx,
    input  swmf_pkg::swmf_entry_t          left,
    input  swmf_pkg::swmf_entry_t          right,
    input  logic                           below,
    output swmf_pkg::swmf_entry_t          ent,
    output logic                           rm
);

    logic [swmf_pkg::SAMPLE_BITS-1:0] value_reg;
    logic [swmf_pkg::SAMPLE_BITS-1:0] value_next;
    logic [swmf_pkg::IDX_BITS-1:0]    age_reg;
    logic [swmf_pkg::IDX_BITS-1:0]    age_next;
    logic                             active;
    logic                             is_last;
    logic                             gt_self;
    logic                             above;
    logic                             gt_b_here;
    logic                             gt_b_left;
    logic                             take_low;
    logic                             take_high;

    always_comb
    begin
        active    = swmf_pkg::WIN_BITS'(idx) < ctl.win;
        is_last   = swmf_pkg::WIN_BITS'(idx) == (ctl.win - 1'b1);
        gt_self   = $signed(value_reg) > $signed(ctl.sample);
        rm        = active && (age_reg == ctl.next_age);
        above     = !below && !rm;
        gt_b_here = above ? gt_self : right.gt;
        gt_b_left = below ? gt_self : left.gt;
        take_low  = !is_last && !gt_b_here;
        take_high = gt_b_left;

        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.push && active)
        begin
            if (ctl.start)
            begin
                value_next = ctl.sample;
                age_next   = is_last ? '0 : idx + 1'b1;
            end
            else if (take_low)
            begin
                value_next = above ? value_reg : right.value;
                age_next   = above ? age_reg : right.age;
            end
            else if (take_high)
            begin
                value_next = below ? value_reg : left.value;
                age_next   = below ? age_reg : left.age;
            end
            else
            begin
                value_next = ctl.sample;
                age_next   = ctl.next_age;
            end
        end

        ent.value = value_reg;
        ent.age   = age_reg;
        ent.gt    = gt_self;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

>>> src/sliding_window_median_filter.sv
// A taken sample updates the cell row and sets pend_reg; the median then moves
// to out_data_reg for m_axis. Throughput: one sample per cycle unless m_axis
// stalls; a record end holds the input for window_size/2 repeats in the cells.
// Every cell compares, shifts and inserts in the same cycle, which sets the rate.
// Reset clears control state and sets window_size to 5; window contents are
// undefined until the first record start, and no clearing pass is run.
// ============================================================================
// Sliding window median filter
// Running median over a row of sorted, age-tagged cells with record handling.
// ============================================================================
module sliding_window_median_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [swmf_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [swmf_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,  // sample
    input  logic                                 s_axis_tuser,  // record_start
    input  logic                                 s_axis_tlast,  // record_end
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [swmf_pkg::SAMPLE_BITS-1:0]     m_axis_tdata,  // median
    output logic                                 m_axis_tlast   // last_of_record
);

    localparam int MW = swmf_pkg::MAX_WINDOW;
    localparam int WB = swmf_pkg::WIN_BITS;
    localparam int IB = swmf_pkg::IDX_BITS;
    localparam int HB = swmf_pkg::HALF_BITS;
    localparam int SB = swmf_pkg::SAMPLE_BITS;

    logic [swmf_pkg::CFG_BITS-1:0] win_size_reg;
    logic [WB-1:0]                 active_reg;
    logic [HB-1:0]                 half_reg;
    logic [IB-1:0]                 med_idx_reg;
    logic [IB-1:0]                 next_age_reg;
    logic [IB-1:0]                 next_age_next;
    logic [HB-1:0]                 warmup_reg;
    logic [HB-1:0]                 warmup_next;
    logic [HB-1:0]                 flush_cnt_reg;
    logic [HB-1:0]                 flush_cnt_next;
    logic [SB-1:0]                 hold_reg;
    logic                          pend_reg;
    logic                          pend_last_reg;
    logic                          out_valid_reg;
    logic [SB-1:0]                 out_data_reg;
    logic                          out_last_reg;

    logic          pend_moves;
    logic          room;
    logic          flushing;
    logic          accept;
    logic          flush_step;
    logic          push;
    logic          start;
    logic [WB-1:0] win_clamp;
    logic [WB-1:0] w_eff;
    logic [HB-1:0] half_eff;
    logic [HB-1:0] warm_eff;
    logic          final_push;
    logic          emit;

    swmf_pkg::swmf_ctl_t   ctl;
    swmf_pkg::swmf_entry_t cell_ent [MW];
    logic [MW-1:0]         rm_vec;
    logic [MW-1:0]         below_vec;

    always_comb
    begin
        if (win_size_reg == '0)
        begin
            win_clamp = WB'(1);
        end
        else if (32'(win_size_reg) > 32'(MW))
        begin
            win_clamp = WB'(MW);
        end
        else
        begin
            win_clamp = WB'(win_size_reg);
        end

        pend_moves    = pend_reg && (!out_valid_reg || m_axis_tready);
        room          = !pend_reg || pend_moves;
        flushing      = flush_cnt_reg != '0;
        s_axis_tready = room && !flushing;
        accept        = s_axis_tvalid && s_axis_tready;
        flush_step    = flushing && room;
        push          = accept || flush_step;
        start         = accept && s_axis_tuser;

        w_eff    = start ? win_clamp : active_reg;
        half_eff = start ? HB'(win_clamp >> 1) : half_reg;
        warm_eff = start ? '0 : warmup_reg;

        final_push = (accept && s_axis_tlast && (half_eff == '0))
                     || (flush_step && (flush_cnt_reg == HB'(1)));
        emit       = push && (warm_eff >= half_eff);

        if (start)
        begin
            next_age_next = (w_eff == WB'(1)) ? '0 : IB'(1);
        end
        else if ((WB + 1)'(next_age_reg) + 1'b1 >= (WB + 1)'(w_eff))
        begin
            next_age_next = '0;
        end
        else
        begin
            next_age_next = next_age_reg + 1'b1;
        end

        if (final_push)
        begin
            warmup_next = '0;
        end
        else if (warm_eff < half_eff)
        begin
            warmup_next = warm_eff + 1'b1;
        end
        else
        begin
            warmup_next = warm_eff;
        end

        if (accept && s_axis_tlast)
        begin
            flush_cnt_next = half_eff;
        end
        else if (flush_step)
        begin
            flush_cnt_next = flush_cnt_reg - 1'b1;
        end
        else
        begin
            flush_cnt_next = flush_cnt_reg;
        end

        ctl.push     = push;
        ctl.start    = start;
        ctl.sample   = accept ? s_axis_tdata : hold_reg;
        ctl.next_age = next_age_reg;
        ctl.win      = w_eff;
    end

    for (genvar i = 0; i < MW; i++)
    begin : g_cell
        swmf_pkg::swmf_entry_t left_ent;
        swmf_pkg::swmf_entry_t right_ent;

        if (i == 0)
        begin : g_first
            assign left_ent     = '0;
            assign below_vec[i] = 1'b0;
        end
        else
        begin : g_inner
            assign left_ent     = cell_ent[i-1];
            assign below_vec[i] = |rm_vec[i-1:0];
        end

        if (i == MW - 1)
        begin : g_end
            assign right_ent = '0;
        end
        else
        begin : g_mid
            assign right_ent = cell_ent[i+1];
        end

        swmf_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .idx   (IB'(i)),
            .left  (left_ent),
            .right (right_ent),
            .below (below_vec[i]),
            .ent   (cell_ent[i]),
            .rm    (rm_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg  <= swmf_pkg::CFG_BITS'(swmf_pkg::WS_RESET);
            active_reg    <= WB'(swmf_pkg::WS_RESET);
            half_reg      <= HB'(swmf_pkg::WS_RESET / 2);
            med_idx_reg   <= IB'(swmf_pkg::WS_RESET - 1 - swmf_pkg::WS_RESET / 2);
            next_age_reg  <= '0;
            warmup_reg    <= '0;
            flush_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_size_reg <= cfg_wr_data;
            end
            if (start)
            begin
                active_reg  <= win_clamp;
                half_reg    <= HB'(win_clamp >> 1);
                med_idx_reg <= IB'(win_clamp - 1'b1 - (win_clamp >> 1));
            end
            if (push)
            begin
                next_age_reg <= next_age_next;
                warmup_reg   <= warmup_next;
            end
            flush_cnt_reg <= flush_cnt_next;

            if (emit)
            begin
                pend_reg      <= 1'b1;
                pend_last_reg <= final_push;
            end
            else if (pend_moves)
            begin
                pend_reg <= 1'b0;
            end

            if (pend_moves)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= s_axis_tdata;
        end
        if (pend_moves)
        begin
            out_data_reg <= cell_ent[med_idx_reg].value;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        flushing |-> !s_axis_tready)
        else $error("Input taken while a record end is still being flushed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        warmup_reg <= half_reg)
        else $error("Warmup count ran past half the window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (WB + 1)'(next_age_reg) < (WB + 1)'(active_reg))
        else $error("Oldest entry tag lies outside the active window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (WB + 1)'(med_idx_reg) < (WB + 1)'(active_reg))
        else $error("Median position lies outside the active window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !out_valid_reg |=> out_valid_reg)
        else $error("A pending median was not moved to the output register.");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Sliding window median filter testbench
// Streams records of signed samples through the filter under random stalls
// on both sides. A sorted, age-tagged window kept here predicts each median
// and end-of-record mark, and every result is checked in order.
// ============================================================================
module tb_top;

    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_PCT      = 13;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 380;
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic signed [swmf_pkg::SAMPLE_BITS-1:0] sample_t;

    localparam sample_t S_MAX = {1'b0, {(swmf_pkg::SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(swmf_pkg::SAMPLE_BITS - 1){1'b0}}};

    typedef struct packed {
        sample_t sample;
        logic    start;
        logic    stop;
    } sample_req_t;

    typedef struct packed {
        sample_t median;
        logic    last;
    } median_res_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    logic [swmf_pkg::CFG_BITS-1:0]    cfg_wr_data   = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [swmf_pkg::SAMPLE_BITS-1:0] s_axis_tdata  = '0;    // sample
    logic                             s_axis_tuser  = 1'b0;  // record_start
    logic                             s_axis_tlast  = 1'b0;  // record_end
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [swmf_pkg::SAMPLE_BITS-1:0] m_axis_tdata;          // median
    logic                             m_axis_tlast;          // last_of_record

    sample_req_t pending_samples[$];
    median_res_t median_expect[$];
    sample_req_t cur_req;
    median_res_t got_res;
    logic        sample_taken = 1'b0;
    logic        steady       = 1'b0;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          items_queued = 0;

    sample_t win_vals[swmf_pkg::MAX_WINDOW];
    int      win_ages[swmf_pkg::MAX_WINDOW];
    int      oldest_age;
    int      warmup_done;
    int      active_win = swmf_pkg::WS_RESET;
    int      window_reg = swmf_pkg::WS_RESET;

    sliding_window_median_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void preload_window(sample_t v);
        for (int i = 0; i < active_win; i++)
        begin
            win_vals[i] = v;
            win_ages[i] = i;
        end
        oldest_age = 0;
    endfunction

    // Slides the window once per pass; a record end adds half a window of
    // repeats, and the first half window of a record stays silent.
    function automatic void median_step(sample_req_t req);
        int      half;
        int      calls;
        int      p;
        int      q;
        int      produced;
        sample_t med;
        if (req.start)
        begin
            active_win = (window_reg < 1) ? 1 :
                         (window_reg > swmf_pkg::MAX_WINDOW) ? swmf_pkg::MAX_WINDOW
                                                             : window_reg;
            preload_window(req.sample);
            warmup_done = 0;
        end
        half     = active_win / 2;
        calls    = req.stop ? half + 1 : 1;
        produced = 0;
        for (int c = 0; c < calls; c++)
        begin
            p = 0;
            for (int i = active_win - 1; i >= 0; i--)
                if (win_ages[i] == oldest_age)
                    p = i;
            for (int i = p; i < active_win - 1; i++)
            begin
                win_vals[i] = win_vals[i + 1];
                win_ages[i] = win_ages[i + 1];
            end
            q = active_win - 1;
            for (int i = active_win - 2; i >= 0; i--)
                if (win_vals[i] > req.sample)
                    q = i;
            for (int i = active_win - 1; i > q; i--)
            begin
                win_vals[i] = win_vals[i - 1];
                win_ages[i] = win_ages[i - 1];
            end
            win_vals[q] = req.sample;
            win_ages[q] = oldest_age;
            oldest_age  = (oldest_age + 1 >= active_win) ? 0 : oldest_age + 1;
            med = win_vals[active_win - 1 - active_win / 2];
            if (warmup_done < half)
                warmup_done++;
            else
            begin
                median_expect.push_back('{median: med, last: 1'b0});
                produced++;
            end
        end
        if (req.stop)
        begin
            if (produced > 0)
                median_expect[median_expect.size() - 1].last = 1'b1;
            warmup_done = 0;
        end
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || sample_taken)
            begin
                if (pending_samples.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_req = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_req.sample;
                    s_axis_tuser  <= cur_req.start;
                    s_axis_tlast  <= cur_req.stop;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        sample_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            median_step(cur_req);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (median_expect.size() == 0)
            begin
                $error("median %0d arrived with no request waiting", $signed(m_axis_tdata));
                error_count++;
            end
            else
            begin
                got_res = median_expect.pop_front();
                if (got_res.median !== m_axis_tdata)
                begin
                    $error("median: expected %0d, actual %0d",
                           got_res.median, $signed(m_axis_tdata));
                    error_count++;
                end
                if (got_res.last !== m_axis_tlast)
                begin
                    $error("last_of_record: expected %0b, actual %0b",
                           got_res.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_sample(sample_t v, logic start, logic stop);
        pending_samples.push_back('{sample: v, start: start, stop: stop});
        items_queued++;
    endtask

    // Holds the sender until every request has gone and every median is back.
    task automatic drain_and_settle();
        while (pending_samples.size() != 0 || s_axis_tvalid || median_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [swmf_pkg::CFG_BITS-1:0] w);
        drain_and_settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        window_reg = int'(w);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic sample_t rand_sample(sample_t prev);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1:       return prev;
            2:       return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_record(int len, logic with_start, logic with_end);
        sample_t prev;
        prev = $urandom;
        for (int k = 0; k < len; k++)
        begin
            prev = rand_sample(prev);
            queue_sample(prev, with_start && k == 0, with_end && k == len - 1);
        end
    endtask

    initial
    begin
        int                            len;
        int                            kind;
        int                            random_target;
        logic [swmf_pkg::CFG_BITS-1:0] win;
        preload_window('0);
        warmup_done = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The reset window of five: a one-sample record, a record shorter
        // than half a window, a full record and a record without a start.
        queue_sample(S_MIN, 1'b1, 1'b1);
        queue_sample(S_MAX, 1'b1, 1'b0);
        queue_sample(S_MIN, 1'b0, 1'b1);
        queue_sample(0, 1'b1, 1'b0);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(1, 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b0, 1'b0);
        queue_sample(S_MIN, 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b0, 1'b1);
        queue_sample(-5, 1'b0, 1'b0);
        queue_sample(7, 1'b0, 1'b1);
        // A zero window acts as a window of one.
        write_window(swmf_pkg::CFG_BITS'(0));
        queue_sample(42, 1'b1, 1'b0);
        queue_sample(-42, 1'b0, 1'b1);
        write_window(swmf_pkg::CFG_BITS'(swmf_pkg::MAX_WINDOW));
        queue_sample(S_MAX, 1'b1, 1'b0);
        queue_sample(S_MIN, 1'b0, 1'b0);
        queue_sample(3, 1'b0, 1'b0);
        queue_sample(-3, 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b0, 1'b1);
        // An even window returns the lower middle value.
        write_window(swmf_pkg::CFG_BITS'(2));
        queue_sample(10, 1'b1, 1'b0);
        queue_sample(20, 1'b1, 1'b0);
        queue_sample(30, 1'b0, 1'b0);
        queue_sample(-30, 1'b0, 1'b1);

        random_target = items_queued + RANDOM_ITEMS;
        for (int phase = 0; items_queued < random_target; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       win = swmf_pkg::CFG_BITS'(1);
                1:       win = swmf_pkg::CFG_BITS'(swmf_pkg::MAX_WINDOW);
                2:       win = swmf_pkg::CFG_BITS'(0);
                3:       win = swmf_pkg::CFG_BITS'(2);
                4:       win = swmf_pkg::CFG_BITS'($urandom_range(0, 31));
                default: win = swmf_pkg::CFG_BITS'(3 + 2 * $urandom_range(0, 3));
            endcase
            write_window(win);
            steady = (phase >= 6 && phase < 9);
            repeat ($urandom_range(1, 4))
            begin
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                   : $urandom_range(1, 12);
                kind = $urandom_range(0, 9);
                run_record(len, kind != 0, kind != 1);
            end
        end

        drain_and_settle();
        if (error_count == 0 && median_expect.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
